// File: rtl/core/dvr_pkg.sv
`default_nettype none

package dvr_pkg;

  // field widths
  localparam int VALUE_W = 32;
  localparam int ID_W    = 8;
  localparam int CNT_W   = 9;

  // value table depth, one entry per id code
  localparam int TABLE_DEPTH = 1 << ID_W;

  // default bound on distinct values
  localparam int DEFAULT_MAX_IDS = 256;

  // operation codes carried on the input beat
  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_MAP    = 2'd1,
    FN_LOOKUP = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_UNASSIGNED = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/dense_value_renumbering_unit.sv
`default_nettype none

// channel  dir  tdata (low bit up)                                   tuser
// in_      in   value_in[31:0] id_in[39:32]                          func[1:0]
// out_     out  id_out[7:0] value_out[39:8] was_new[40]
//               used_count[49:41] zero pad[55:50]                    status[1:0]
//
// clear, unused func: accept goes straight to the done state
// lookup: one table read, registered read data, then the done state
// map: searches at most the ids in use before the beat;
//   the linear search reads one table entry per cycle through the single
//   memory port, insert writes in the last cycle
// rst_n (synchronous) empties the table by zeroing the id count; the
//   memory itself is not cleared, entries at or above the count are never read
// a result waiting on out_tready holds the unit in its done state; the next
//   beat may still be taken while an earlier result sits in the output register

module dense_value_renumbering_unit
  import dvr_pkg::*;
#(
  parameter int MAX_IDS = DEFAULT_MAX_IDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value_in, id_in
  input  wire logic [1:0]  in_tuser,   // func

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // id_out, value_out, was_new, used_count
  output logic [1:0]       out_tuser   // status
);

  // usable ids are bounded by the table depth as well as by MAX_IDS
  localparam int CAP_INT = (MAX_IDS < TABLE_DEPTH) ? MAX_IDS : TABLE_DEPTH;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(CAP_INT);
  localparam int OUT_USED_W = ID_W + VALUE_W + 1 + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;       // ids in use
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt; // a read is in flight for chk_idx
  logic [ID_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;

  // pending result
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic               res_new_r, res_new_nxt;
  logic [CNT_W-1:0]   res_used_r, res_used_nxt;
  status_t            res_stat_r, res_stat_nxt;

  // output register
  logic               out_vld_r, out_vld_nxt;
  logic [55:0]        out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;

  // table port
  logic               ram_en, ram_we;
  logic [ID_W-1:0]    ram_addr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               in_fire;
  logic [VALUE_W-1:0] in_value;
  logic [ID_W-1:0]    in_id;

  assign in_tready = (st_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_value  = in_tdata[VALUE_W-1:0];
  assign in_id     = in_tdata[VALUE_W+ID_W-1:VALUE_W];

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    scan_idx_nxt = scan_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    val_nxt      = val_r;
    res_id_nxt   = res_id_r;
    res_val_nxt  = res_val_r;
    res_new_nxt  = res_new_r;
    res_used_nxt = res_used_r;
    res_stat_nxt = res_stat_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = scan_idx_r[ID_W-1:0];

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt      = in_value;
          res_id_nxt   = '0;
          res_val_nxt  = '0;
          res_new_nxt  = 1'b0;
          res_used_nxt = cnt_r;
          res_stat_nxt = STAT_OK;
          st_nxt       = S_DONE;
          case (in_tuser)
            FN_CLEAR: begin
              cnt_nxt      = '0;
              res_used_nxt = '0;
            end
            FN_MAP: begin
              scan_idx_nxt = '0;
              chk_vld_nxt  = 1'b0;
              st_nxt       = S_SCAN;
            end
            FN_LOOKUP: begin
              res_id_nxt = in_id;
              if ({1'b0, in_id} < cnt_r) begin
                ram_en   = 1'b1;
                ram_addr = in_id;
                st_nxt   = S_READ;
              end else begin
                res_stat_nxt = STAT_UNASSIGNED;
              end
            end
            default: begin
              // unused code, result stays all zero but the count
            end
          endcase
        end
      end

      S_READ: begin
        res_val_nxt = ram_rdata;
        st_nxt      = S_DONE;
      end

      S_SCAN: begin
        if (chk_vld_r && (ram_rdata == val_r)) begin
          // hit on the entry read last cycle
          res_id_nxt  = chk_idx_r;
          res_val_nxt = val_r;
          st_nxt      = S_DONE;
        end else if (scan_idx_r < cnt_r) begin
          ram_en       = 1'b1;
          ram_addr     = scan_idx_r[ID_W-1:0];
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_idx_r[ID_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else if (cnt_r < CAPACITY) begin
          // miss, append at the next free id
          ram_en       = 1'b1;
          ram_we       = 1'b1;
          ram_addr     = cnt_r[ID_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
          res_id_nxt   = cnt_r[ID_W-1:0];
          res_val_nxt  = val_r;
          res_new_nxt  = 1'b1;
          res_used_nxt = cnt_r + 1'b1;
          st_nxt       = S_DONE;
        end else begin
          res_stat_nxt = STAT_FULL;
          st_nxt       = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{(56 - OUT_USED_W){1'b0}}, res_used_r, res_new_r,
                          res_val_r, res_id_r};
          out_user_nxt = res_stat_r;
          st_nxt       = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    val_r      <= val_nxt;
    res_id_r   <= res_id_nxt;
    res_val_r  <= res_val_nxt;
    res_new_r  <= res_new_nxt;
    res_used_r <= res_used_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // value table, one word per id
  dvr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// File: rtl/core/dvr_ram.sv
`default_nettype none

module dvr_ram
  import dvr_pkg::*;
#(
  parameter int WIDTH = VALUE_W,
  parameter int DEPTH = TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire
